@@ hw/rtl/cti_pkg.sv @@
// Shared constants, types and delay tables of the convolutional time interleaver.
`timescale 1ns / 1ps

package cti_pkg;

    // Store geometry.
    localparam int MAX_FRAME_BYTES = 8192;
    localparam int SLOT_COUNT      = 16;
    localparam int SLOT_W          = $clog2(SLOT_COUNT);
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int ADDR_W          = SLOT_W + POS_W;
    localparam int LANE_DEPTH      = SLOT_COUNT * MAX_FRAME_BYTES;

    // Field and register widths.
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 14;

    // Fill counts reach MAX_FRAME_BYTES itself.
    localparam int FILL_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W  = (CFG_W > FILL_W) ? CFG_W : FILL_W;

    // Frame length limits after the lowest bit is dropped.
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_FRAME_BYTES & ~1);

    localparam logic [CFG_W-1:0] FRAME_BYTES_RESET = CFG_W'(6912);

    // Output buffer: a depth of four with at most three entries committed.
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);
    localparam logic [OBUF_CNT_W-1:0] OBUF_LIMIT = OBUF_CNT_W'(OBUF_DEPTH - 1);

    typedef logic [SLOT_W-1:0] t_delay;

    // Frame delays in table order: entry j feeds output bit BYTE_W-1-j.
    localparam t_delay EVEN_DELAY [BYTE_W] = '{
        t_delay'(0), t_delay'(8), t_delay'(4), t_delay'(12),
        t_delay'(2), t_delay'(10), t_delay'(6), t_delay'(14)
    };
    localparam t_delay ODD_DELAY [BYTE_W] = '{
        t_delay'(1), t_delay'(9), t_delay'(5), t_delay'(13),
        t_delay'(3), t_delay'(11), t_delay'(7), t_delay'(15)
    };

    // Memory accesses issued by the control for one accepted byte.
    typedef struct packed {
        logic [ADDR_W-1:0]             wr_addr;
        logic [BYTE_W-1:0][ADDR_W-1:0] rd_addr;
        logic [BYTE_W-1:0]             keep;
        logic                          even;
        logic                          frame_end;
    } t_req;

    // One result held in the output buffer.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              frame_end;
    } t_item;

endpackage

@@ hw/rtl/cti_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module cti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/cti_ctrl.sv @@
// Frame position, newest slot, per-age fill counts and lane address generation.
`timescale 1ns / 1ps

module cti_ctrl
    import cti_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_accept,
    output t_req             o_req
);

    logic [CFG_W-1:0]  r_frame_bytes;
    logic [POS_W-1:0]  r_byte_pos;
    logic [POS_W-1:0]  n_byte_pos;
    logic [SLOT_W-1:0] r_newest;
    logic [SLOT_W-1:0] n_newest;
    // Written prefix length of the slot that is k frames old.
    logic [FILL_W-1:0] r_fill [SLOT_COUNT];
    logic [FILL_W-1:0] n_fill [SLOT_COUNT];

    logic [LEN_W-1:0]  len_raw;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  pos_inc;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic [FILL_W-1:0] fill_upd;

    // Effective frame length: lowest bit dropped, then clamped.
    always_comb begin
        len_raw = LEN_W'({r_frame_bytes[CFG_W-1:1], 1'b0});
        if (len_raw < LEN_MIN) begin
            len = LEN_MIN;
        end else if (len_raw > LEN_CAP) begin
            len = LEN_CAP;
        end else begin
            len = len_raw;
        end
    end

    // Position of this byte, clamped to the frame, and the end-of-frame test.
    always_comb begin
        pos_ext = LEN_W'(r_byte_pos);
        if (pos_ext >= len) begin
            pos_ext = len - LEN_W'(1);
        end
        pos_inc = pos_ext + LEN_W'(1);
        pos     = pos_ext[POS_W-1:0];
        last    = (pos_inc >= len);
    end

    // Lane addresses and the mask of entries that have been written since reset.
    always_comb begin
        t_delay            d;
        logic [FILL_W-1:0] fill_sel;
        o_req.wr_addr   = {r_newest, pos};
        o_req.even      = ~pos[0];
        o_req.frame_end = last;
        for (int k = 0; k < BYTE_W; k++) begin
            if (pos[0]) begin
                d        = ODD_DELAY[BYTE_W-1-k];
                fill_sel = r_fill[ODD_DELAY[BYTE_W-1-k]];
            end else begin
                d        = EVEN_DELAY[BYTE_W-1-k];
                fill_sel = r_fill[EVEN_DELAY[BYTE_W-1-k]];
            end
            o_req.rd_addr[k] = {SLOT_W'(r_newest - d), pos};
            // A zero delay is served from the incoming byte itself.
            o_req.keep[k]    = (d != t_delay'(0)) && (fill_sel > FILL_W'(pos));
        end
    end

    // Next position, slot and fill counts.
    always_comb begin
        fill_upd = (r_fill[0] > FILL_W'(pos_inc)) ? r_fill[0] : FILL_W'(pos_inc);
        n_byte_pos = r_byte_pos;
        n_newest   = r_newest;
        n_fill     = r_fill;
        if (i_accept) begin
            if (last) begin
                n_byte_pos = '0;
                n_newest   = r_newest + SLOT_W'(1);
                // The oldest slot is reused as the newest one.
                n_fill[0]  = r_fill[SLOT_COUNT-1];
                n_fill[1]  = fill_upd;
                for (int k = 2; k < SLOT_COUNT; k++) begin
                    n_fill[k] = r_fill[k-1];
                end
            end else begin
                n_byte_pos = pos_inc[POS_W-1:0];
                n_fill[0]  = fill_upd;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FRAME_BYTES_RESET;
            r_byte_pos    <= '0;
            r_newest      <= '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            if (i_cfg_wr) begin
                r_frame_bytes <= i_cfg_data;
            end
            r_byte_pos <= n_byte_pos;
            r_newest   <= n_newest;
            r_fill     <= n_fill;
        end
    end

endmodule

@@ hw/rtl/cti_obuf.sv @@
// Four-entry output buffer that decouples the memory read from the output stall.
`timescale 1ns / 1ps

module cti_obuf
    import cti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_inflight,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_stall
);

    t_item                 r_mem [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0] r_wr_ptr;
    logic [OBUF_PTR_W-1:0] r_rd_ptr;
    logic [OBUF_CNT_W-1:0] r_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    // Entries held plus the read still in flight must leave room for one more.
    assign o_full  = ((r_count + OBUF_CNT_W'(i_inflight)) >= OBUF_LIMIT);

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OBUF_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OBUF_PTR_W'(1);
            end
            r_count <= r_count + OBUF_CNT_W'(i_push) - OBUF_CNT_W'(pop);
        end
    end

endmodule

@@ hw/rtl/convolutional_time_interleaver.sv @@
// Top level of the 16-frame convolutional time interleaver.
// The block takes one byte per clock cycle while o_in_stall is low and delivers one interleaved
// byte for each. A result is offered once the read stage has registered it and it has been
// written into the output buffer. The frame store
// is held in eight one-bit lane memories of 16 x 8192 entries; each accepted byte writes one bit
// into every lane and reads every lane once, so the single write and single read port of each
// lane memory set the rate of one byte per cycle. The bit with no delay is taken directly from
// the incoming byte. A four-entry output buffer absorbs the registered memory read while the
// output is stalled. No clearing pass follows reset: per-age fill counts mark which store entries
// have been written, and entries not yet written read as zero, so bytes are taken as soon as
// reset is released. The frame length register may be written at any time the block is idle.
`timescale 1ns / 1ps

module convolutional_time_interleaver
    import cti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_frame_end
);

    t_req              req;
    logic              accept;
    logic [BYTE_W-1:0] rd_bits;
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_keep;
    logic              r_s1_fwd;
    logic              r_s1_end;
    t_item             s1_item;
    t_item             out_item;
    logic              obuf_full;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = obuf_full;

    // Frame position and address generation.
    cti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .o_req      (req)
    );

    // One lane memory per bit of the byte.
    for (genvar k = 0; k < BYTE_W; k++) begin : g_lane
        cti_ram #(
            .WIDTH (1),
            .DEPTH (LANE_DEPTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (accept),
            .i_wr_addr (req.wr_addr),
            .i_wr_data (i_in_byte[k]),
            .i_rd_en   (accept),
            .i_rd_addr (req.rd_addr[k]),
            .o_rd_data (rd_bits[k])
        );
    end

    // Read stage: side information that travels with the memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_keep <= req.keep;
            r_s1_fwd  <= req.even && i_in_byte[BYTE_W-1];
            r_s1_end  <= req.frame_end;
        end
    end

    // Assemble the result: unwritten entries read as zero.
    always_comb begin
        s1_item.out_byte  = (rd_bits & r_s1_keep) | {r_s1_fwd, (BYTE_W-1)'(0)};
        s1_item.frame_end = r_s1_end;
    end

    // Output buffer.
    cti_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_s1_valid),
        .i_item     (s1_item),
        .i_inflight (r_s1_valid),
        .o_full     (obuf_full),
        .o_valid    (o_out_valid),
        .o_item     (out_item),
        .i_stall    (i_out_stall)
    );

    assign o_out_byte  = out_item.out_byte;
    assign o_frame_end = out_item.frame_end;

endmodule

@@ hw/rtl/cti_chk.sv @@
// Port-level checker of the convolutional time interleaver and its bind.
`timescale 1ns / 1ps

module cti_chk
    import cti_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_frame_end
);

    logic in_acc;
    logic out_acc;
    logic r_prev_end;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Frame end flag of the last delivered transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_end <= 1'b0;
        end else if (out_acc) begin
            r_prev_end <= o_frame_end;
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_byte) && $stable(o_frame_end))
        else $error("output payload changed while stalled");

    // Every accepted byte has a result on offer once it has passed the read stage into the output buffer.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 o_out_valid)
        else $error("no result two cycles after an accepted byte");

    // Frames are at least two bytes long, so frame ends never follow each other.
    a_frame_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_prev_end |-> !o_frame_end)
        else $error("two consecutive transactions marked as frame end");

    // Reset empties the block and opens the input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind convolutional_time_interleaver cti_chk u_cti_chk (.*);
